@@ src/stexp_pkg.sv @@
// ----------------------------------------------------------------------------
// stexp_pkg
// Types and constants for the sprite entry tile expander: sequencer states,
// attribute field positions and the priority class to layer mask table.
// ----------------------------------------------------------------------------
package stexp_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // attribute word fields
    localparam int unsigned ATTR_EN_BIT   = 15;
    localparam int unsigned ATTR_FX_BIT   = 14;
    localparam int unsigned ATTR_FY_BIT   = 13;
    localparam int unsigned ATTR_W_MSB    = 12;
    localparam int unsigned ATTR_W_LSB    = 10;
    localparam int unsigned ATTR_H_MSB    = 9;
    localparam int unsigned ATTR_H_LSB    = 7;
    localparam int unsigned ATTR_PAL_MSB  = 5;

    // position words
    localparam int unsigned POS_NEG_BIT   = 15;
    localparam int unsigned POS_MSB       = 8;

    localparam int unsigned CODE_W        = 14;
    localparam int unsigned PAL_W         = 6;
    localparam int unsigned POS_W         = 11;
    localparam int unsigned IDX_W         = 3;
    localparam int unsigned MASK_W        = 8;

    // priority classes
    localparam logic [1:0] PRI_CLASS0 = 2'd0;
    localparam logic [1:0] PRI_CLASS1 = 2'd1;
    localparam logic [1:0] PRI_CLASS2 = 2'd2;

    localparam logic [MASK_W-1:0] PRI_MASK0 = 8'hf0;
    localparam logic [MASK_W-1:0] PRI_MASK1 = 8'hfc;
    localparam logic [MASK_W-1:0] PRI_MASK2 = 8'hfe;
    localparam logic [MASK_W-1:0] PRI_MASK3 = 8'h00;

    function automatic logic [MASK_W-1:0] pri_mask(input logic [1:0] pri_class);
        logic [MASK_W-1:0] m;
        case (pri_class)
            PRI_CLASS0: m = PRI_MASK0;
            PRI_CLASS1: m = PRI_MASK1;
            PRI_CLASS2: m = PRI_MASK2;
            default:    m = PRI_MASK3;
        endcase
        return m;
    endfunction

endpackage

@@ src/sprite_entry_tile_expander.sv @@
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander
// Decodes one four-word sprite list entry and emits its 16x16 tiles one by
// one in column-major order, with mirrored placement and a last marker.
// ----------------------------------------------------------------------------
// An enabled entry of W by H tiles (1..8 each) produces W*H output words, one
// per cycle while the output is not stalled, and holds the input stalled until
// its final tile is loaded into the output register; the column/row counter pair
// and the x and y position adders step through the tiles. A disabled entry is
// taken without entering the run state and produces nothing. The next entry is
// accepted while the final tile still waits in the output register.
// vertical_offset is written through cfg_we/cfg_wdata and is applied to y when an entry is taken.
module sprite_entry_tile_expander
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] attr_word,
    input  logic [15:0] code_word,
    input  logic [15:0] x_word,
    input  logic [15:0] y_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] tile_code,
    output logic [5:0]  palette,
    output logic        mirror_x,
    output logic        mirror_y,
    output logic signed [10:0] pos_x,
    output logic signed [10:0] pos_y,
    output logic [7:0]  priority_mask,
    output logic        last
);

    localparam int unsigned CW = stexp_pkg::CODE_W;
    localparam int unsigned PW = stexp_pkg::POS_W;
    localparam int unsigned IW = stexp_pkg::IDX_W;
    localparam int unsigned MW = stexp_pkg::MASK_W;
    localparam int unsigned LW = stexp_pkg::PAL_W;

    stexp_pkg::state_t state_reg, state_next;

    logic [7:0]     voff_reg;

    // latched entry
    logic [CW-1:0]  tile_reg, tile_next;
    logic [LW-1:0]  pal_reg, pal_next;
    logic           fx_reg, fx_next;
    logic           fy_reg, fy_next;
    logic [IW-1:0]  dx_reg, dx_next;
    logic [IW-1:0]  dy_reg, dy_next;
    logic [IW-1:0]  ax_reg, ax_next;
    logic [IW-1:0]  ay_reg, ay_next;
    logic [PW-1:0]  x0_reg, x0_next;
    logic [PW-1:0]  y0_reg, y0_next;
    logic [MW-1:0]  pmask_reg, pmask_next;

    // output word
    logic           ovalid_reg, ovalid_next;
    logic [CW-1:0]  ocode_reg, ocode_next;
    logic [LW-1:0]  opal_reg, opal_next;
    logic           ofx_reg, ofx_next;
    logic           ofy_reg, ofy_next;
    logic [PW-1:0]  ox_reg, ox_next;
    logic [PW-1:0]  oy_reg, oy_next;
    logic [MW-1:0]  omask_reg, omask_next;
    logic           olast_reg, olast_next;

    logic           accept;
    logic           slot_free;
    logic           load;
    logic           tile_last;
    logic [IW-1:0]  cx, cy;
    logic [PW-1:0]  in_x, in_y;

    assign accept    = in_valid && (state_reg == stexp_pkg::ST_IDLE);
    assign slot_free = !ovalid_reg || !out_stall;
    assign load      = (state_reg == stexp_pkg::ST_RUN) && slot_free;
    assign tile_last = (ax_reg == dx_reg) && (ay_reg == dy_reg);

    // negative flag weighs -512: a 10-bit two's complement value, sign-extended
    assign in_x = {x_word[stexp_pkg::POS_NEG_BIT], x_word[stexp_pkg::POS_NEG_BIT],
                   x_word[stexp_pkg::POS_MSB:0]};
    assign in_y = {y_word[stexp_pkg::POS_NEG_BIT], y_word[stexp_pkg::POS_NEG_BIT],
                   y_word[stexp_pkg::POS_MSB:0]};

    // mirrored column/row index
    assign cx = fx_reg ? (dx_reg - ax_reg) : ax_reg;
    assign cy = fy_reg ? (dy_reg - ay_reg) : ay_reg;

    always_comb
    begin
        state_next  = state_reg;
        tile_next   = tile_reg;
        pal_next    = pal_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        pmask_next  = pmask_reg;

        ovalid_next = ovalid_reg && out_stall;
        ocode_next  = ocode_reg;
        opal_next   = opal_reg;
        ofx_next    = ofx_reg;
        ofy_next    = ofy_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        omask_next  = omask_reg;
        olast_next  = olast_reg;

        case (state_reg)
            stexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    tile_next  = code_word[CW-1:0];
                    pal_next   = attr_word[stexp_pkg::ATTR_PAL_MSB:0];
                    fx_next    = attr_word[stexp_pkg::ATTR_FX_BIT];
                    fy_next    = attr_word[stexp_pkg::ATTR_FY_BIT];
                    dx_next    = attr_word[stexp_pkg::ATTR_W_MSB:stexp_pkg::ATTR_W_LSB];
                    dy_next    = attr_word[stexp_pkg::ATTR_H_MSB:stexp_pkg::ATTR_H_LSB];
                    ax_next    = '0;
                    ay_next    = '0;
                    x0_next    = in_x;
                    y0_next    = in_y - {{(PW-8){1'b0}}, voff_reg};
                    pmask_next = stexp_pkg::pri_mask(code_word[15:14]);
                    // disabled entry is consumed with no output
                    if (attr_word[stexp_pkg::ATTR_EN_BIT])
                        state_next = stexp_pkg::ST_RUN;
                end
            end
            stexp_pkg::ST_RUN:
            begin
                if (load)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = tile_reg;
                    opal_next   = pal_reg;
                    ofx_next    = fx_reg;
                    ofy_next    = fy_reg;
                    ox_next     = x0_reg + {{(PW-IW-4){1'b0}}, cx, 4'b0000};
                    oy_next     = y0_reg + {{(PW-IW-4){1'b0}}, cy, 4'b0000};
                    omask_next  = pmask_reg;
                    olast_next  = tile_last;
                    tile_next   = tile_reg + {{(CW-1){1'b0}}, 1'b1};
                    if (ay_reg == dy_reg)
                    begin
                        ay_next = '0;
                        ax_next = ax_reg + {{(IW-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        ay_next = ay_reg + {{(IW-1){1'b0}}, 1'b1};
                    end
                    if (tile_last)
                        state_next = stexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stexp_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            voff_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                voff_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg  <= tile_next;
        pal_reg   <= pal_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        pmask_reg <= pmask_next;
        ocode_reg <= ocode_next;
        opal_reg  <= opal_next;
        ofx_reg   <= ofx_next;
        ofy_reg   <= ofy_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        omask_reg <= omask_next;
        olast_reg <= olast_next;
    end

    assign in_stall      = (state_reg != stexp_pkg::ST_IDLE);
    assign out_valid     = ovalid_reg;
    assign tile_code     = ocode_reg;
    assign palette       = opal_reg;
    assign mirror_x      = ofx_reg;
    assign mirror_y      = ofy_reg;
    assign pos_x         = ox_reg;
    assign pos_y         = oy_reg;
    assign priority_mask = omask_reg;
    assign last          = olast_reg;

`ifndef SYNTHESIS
    // the final tile of an entry returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load && tile_last |=> state_reg == stexp_pkg::ST_IDLE)
        else $error("sequencer did not return to idle after final tile");

    // a new output word only appears from the running state
    a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == stexp_pkg::ST_RUN))
        else $error("output word loaded outside running state");

    // tile code steps by one per emitted tile within an entry
    a_code_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && !tile_last |=> tile_reg == $past(tile_reg) + {{(CW-1){1'b0}}, 1'b1})
        else $error("tile code did not advance by one");

    // the loaded word carries the last marker exactly when it ends the entry
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> ovalid_reg && (olast_reg == (state_reg == stexp_pkg::ST_IDLE)))
        else $error("last marker does not match sequencer end");
`endif

endmodule
